/* hdl/iecr_pkg.sv */
// ----------------------------------------------------------------------------
// iecr_pkg
// Shared codes, widths and lane control type of the edge-renormalising
// image convolution block.
// ----------------------------------------------------------------------------
package iecr_pkg;

  localparam int CHAN_W    = 16;
  localparam int OUT_W     = 24;
  localparam int ROW_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam int NUM_CH    = 3;
  localparam int WSUM_ONE  = 22;

  typedef enum logic [1:0] {
    REQ_COEFF = 2'd0,
    REQ_PIXEL = 2'd1,
    REQ_FLUSH = 2'd2
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_ROWS  = 2'd0,
    CFG_IMAGE_COLS  = 2'd1,
    CFG_KERNEL_ROWS = 2'd2,
    CFG_KERNEL_COLS = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic wr_en;
    logic take;
    logic clr;
    logic div_start;
  } lane_ctl_t;

endpackage

/* hdl/iecr_if.sv */
// ----------------------------------------------------------------------------
// iecr_in_if / iecr_out_if
// Valid/ready channels for requests into and filtered pixels out of the block.
// ----------------------------------------------------------------------------
interface iecr_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        req_type;
  logic [7:0]                        coeff_index;
  logic signed [31:0]                coeff_value;
  logic [iecr_pkg::CHAN_W-1:0]       red_in;
  logic [iecr_pkg::CHAN_W-1:0]       green_in;
  logic [iecr_pkg::CHAN_W-1:0]       blue_in;

  modport source (output valid, req_type, coeff_index, coeff_value, red_in, green_in,
                  blue_in, input ready);
  modport sink (input valid, req_type, coeff_index, coeff_value, red_in, green_in,
                blue_in, output ready);
endinterface

interface iecr_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [iecr_pkg::OUT_W-1:0] red_out;
  logic signed [iecr_pkg::OUT_W-1:0] green_out;
  logic signed [iecr_pkg::OUT_W-1:0] blue_out;
  logic                              last_of_frame;

  modport source (output valid, red_out, green_out, blue_out, last_of_frame, input ready);
  modport sink (input valid, red_out, green_out, blue_out, last_of_frame, output ready);
endinterface

/* hdl/iecr_lane.sv */
// ----------------------------------------------------------------------------
// iecr_lane
// One colour channel: line store, window multiply-accumulate and a radix-2
// restoring divider giving the truncated quotient magnitude and sign.
// ----------------------------------------------------------------------------
module iecr_lane #(
  parameter int DEPTH      = 16400,
  parameter int COEFF_BITS = 32,
  parameter int ACC_W      = 57,
  parameter int WS_W       = 40,
  localparam int AW        = $clog2(DEPTH)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  iecr_pkg::lane_ctl_t           ctl,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [iecr_pkg::CHAN_W-1:0]   wr_data,
  input  logic [AW-1:0]                 rd_addr,
  input  logic signed [COEFF_BITS-1:0]  wgt,
  input  logic [WS_W-1:0]               divisor,
  input  logic                          div_neg,
  output logic [ACC_W-1:0]              q_mag,
  output logic                          q_neg,
  output logic                          done
);

  localparam int PROD_W = iecr_pkg::CHAN_W + 1 + COEFF_BITS;
  localparam int CNT_W  = $clog2(ACC_W + 1);

  logic [iecr_pkg::CHAN_W-1:0] mem [DEPTH];
  logic [iecr_pkg::CHAN_W-1:0] rd_q_r;
  logic signed [PROD_W-1:0]    prod_r;
  logic                        ptake_r;
  logic signed [ACC_W-1:0]     acc_r;
  logic [ACC_W-1:0]            dvd_r;
  logic [WS_W-1:0]             rem_r;
  logic                        qneg_r;
  logic                        busy_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [WS_W:0]               trial;
  logic [WS_W:0]               diff;
  logic                        ge;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    prod_r <= $signed({1'b0, rd_q_r}) * wgt;
  end

  assign trial = {rem_r, dvd_r[ACC_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptake_r <= 1'b0;
      busy_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      ptake_r <= ctl.take;
      if (ctl.clr) begin
        acc_r <= '0;
      end else if (ptake_r) begin
        acc_r <= acc_r + ACC_W'(prod_r);
      end
      if (ctl.div_start) begin
        dvd_r  <= acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
        rem_r  <= '0;
        qneg_r <= acc_r[ACC_W-1] ^ div_neg;
        cnt_r  <= CNT_W'(ACC_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        dvd_r <= {dvd_r[ACC_W-2:0], ge};
        rem_r <= ge ? diff[WS_W-1:0] : trial[WS_W-1:0];
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign q_mag = dvd_r;
  assign q_neg = qneg_r;
  assign done  = !busy_r;

endmodule

/* hdl/iecr_merge.sv */
// ----------------------------------------------------------------------------
// iecr_merge
// Gathers the three lane quotients, saturates them to 24 bits and holds the
// result in the output register until the receiver takes it.
// ----------------------------------------------------------------------------
module iecr_merge #(
  parameter int ACC_W = 57
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load,
  input  logic [ACC_W-1:0]             q_mag [iecr_pkg::NUM_CH],
  input  logic [iecr_pkg::NUM_CH-1:0]  q_neg,
  input  logic                         last,
  output logic                         free,
  iecr_out_if.source                   out_ch
);

  localparam int OW = iecr_pkg::OUT_W;

  logic          valid_r;
  logic [OW-1:0] sat [iecr_pkg::NUM_CH];
  logic [OW-1:0] red_r;
  logic [OW-1:0] green_r;
  logic [OW-1:0] blue_r;
  logic          last_r;

  function automatic logic [OW-1:0] saturate(input logic [ACC_W-1:0] mag, input logic neg);
    logic [OW-1:0] low;
    low = OW'(mag);
    if (neg) begin
      if (mag > ACC_W'(8388608)) begin
        return 24'h800000;
      end
      return OW'(0) - low;
    end
    if (mag > ACC_W'(8388607)) begin
      return 24'h7FFFFF;
    end
    return low;
  endfunction

  always_comb begin
    for (int i = 0; i < iecr_pkg::NUM_CH; i++) begin
      sat[i] = saturate(q_mag[i], q_neg[i]);
    end
  end

  assign free = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        red_r   <= sat[0];
        green_r <= sat[1];
        blue_r  <= sat[2];
        last_r  <= last;
      end else if (out_ch.ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.red_out       = red_r;
  assign out_ch.green_out     = green_r;
  assign out_ch.blue_out      = blue_r;
  assign out_ch.last_of_frame = last_r;

endmodule

/* hdl/image_convolution_edge_renorm.sv */
// ----------------------------------------------------------------------------
// image_convolution_edge_renorm
// 2D convolution of an RGB raster stream, renormalised by in-frame weights.
// ----------------------------------------------------------------------------
// Requests arrive on in_ch: coefficient writes, pixels in raster order and
// flush requests that drain the outputs still pending after the last pixel.
// Filtered pixels leave on out_ch through an output register, so a new
// request is taken while a result still waits for the receiver.
// A coefficient write, or a pixel/flush that yields no output, leaves the block idle.
// A request that yields an output steps through S_SETUP, S_RUN, S_DRAIN1,
// S_DRAIN2, S_DIVST, S_DIV and S_OUT. S_RUN reads one kernel position at a
// time through the single read port of each channel's line store; each lane's
// divider then makes one quotient bit per cycle, ACC_W bits in all (57 with
// defaults). Outputs follow pixels by ((kr-1)/2)*cols + (kc-1)/2 pixels.
// cfg_we writes one register per cycle; use it only while the block is idle.
// A write restarts the frame. Reset clears counters and sets all registers
// to 1; kernel and line stores hold nothing until written.
// When out_ch stalls, a finished result waits in the output register and the
// next output-producing request stalls in its final step.
// ----------------------------------------------------------------------------
module image_convolution_edge_renorm #(
  parameter int MAX_KERNEL = 16,
  parameter int MAX_COLS   = 1024,
  parameter int PIXEL_BITS = 16,
  parameter int COEFF_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  iecr_in_if.sink                            in_ch,
  iecr_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [iecr_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [iecr_pkg::CFG_DAT_W-1:0]     cfg_data
);

  localparam int RING   = MAX_KERNEL * MAX_COLS + MAX_KERNEL;
  localparam int RA_W   = $clog2(RING);
  localparam int PEND_W = $clog2(RING + 1);
  localparam int COL_W  = $clog2(MAX_COLS + 1);
  localparam int KD_W   = $clog2(MAX_KERNEL + 1);
  localparam int KS     = MAX_KERNEL * MAX_KERNEL;
  localparam int KA_W   = (KS > 1) ? $clog2(KS) : 1;
  localparam int ROW_W  = iecr_pkg::ROW_W;
  localparam int LOGK2  = 2 * $clog2(MAX_KERNEL);
  localparam int WS_W   = (COEFF_BITS + LOGK2 > 24) ? COEFF_BITS + LOGK2 : 24;
  localparam int ACC_W  = iecr_pkg::CHAN_W + COEFF_BITS + LOGK2 + 1;
  localparam int PIX_SH = iecr_pkg::CHAN_W - PIXEL_BITS;
  localparam int NCH    = iecr_pkg::NUM_CH;

  typedef enum logic [2:0] {
    S_IDLE, S_SETUP, S_RUN, S_DRAIN1, S_DRAIN2, S_DIVST, S_DIV, S_OUT
  } state_t;

  state_t                    state_r;
  logic [ROW_W-1:0]          rows_r;
  logic [COL_W-1:0]          cols_r;
  logic [KD_W-1:0]           kr_r;
  logic [KD_W-1:0]           kc_r;
  logic [ROW_W-1:0]          irow_r;
  logic [COL_W-1:0]          icol_r;
  logic [ROW_W-1:0]          orow_r;
  logic [COL_W-1:0]          ocol_r;
  logic [RA_W-1:0]           wp_r;
  logic [RA_W-1:0]           op_r;
  logic [PEND_W-1:0]         pend_r;
  logic                      draining_r;
  logic [RA_W-1:0]           ra_r;
  logic [RA_W-1:0]           ca_r;
  logic signed [ROW_W+1:0]   pr_r;
  logic signed [COL_W:0]     pc_r;
  logic signed [COL_W:0]     pc0_r;
  logic [KD_W-1:0]           ki_r;
  logic [KD_W-1:0]           kj_r;
  logic                      take_q_r;
  logic signed [COEFF_BITS-1:0] w_q_r;
  logic signed [WS_W-1:0]    wsum_r;
  logic signed [COEFF_BITS-1:0] kmem [KS];

  logic                      acc_in;
  logic                      acc_pix;
  logic                      kwr;
  logic [PEND_W-1:0]         lat_c;
  logic [PEND_W-1:0]         pend_new;
  logic                      emit_pix;
  logic                      in_end;
  logic                      out_end;
  logic [RA_W:0]             back_c;
  logic [RA_W:0]             start_c;
  logic [RA_W:0]             rsum_c;
  logic [RA_W-1:0]           ra_nxt;
  logic [RA_W-1:0]           ca_step;
  logic                      inb;
  logic [KA_W-1:0]           kidx;
  logic                      row_last;
  logic [WS_W-1:0]           divisor;
  logic                      div_neg;
  logic [iecr_pkg::CHAN_W-1:0] px [NCH];
  logic [ACC_W-1:0]          q_mag [NCH];
  logic [NCH-1:0]            q_neg;
  logic [NCH-1:0]            lane_done;
  logic                      free;
  logic                      load;
  logic                      last;
  iecr_pkg::lane_ctl_t       lane_ctl;
  logic [10:0]               cols_raw;
  logic [4:0]                k_raw;
  logic [COL_W-1:0]          cols_cl;
  logic [KD_W-1:0]           k_cl;

  assign in_ch.ready = (state_r == S_IDLE);
  assign acc_in      = in_ch.valid && in_ch.ready;
  assign acc_pix     = acc_in && (in_ch.req_type == iecr_pkg::REQ_PIXEL);
  assign kwr         = acc_in && (in_ch.req_type == iecr_pkg::REQ_COEFF)
                       && (32'(in_ch.coeff_index) < KS);

  assign px[0] = in_ch.red_in << PIX_SH;
  assign px[1] = in_ch.green_in << PIX_SH;
  assign px[2] = in_ch.blue_in << PIX_SH;

  // Register clamping
  always_comb begin
    cols_raw = cfg_data[10:0];
    k_raw    = cfg_data[4:0];
    if (cols_raw == 11'd0) begin
      cols_cl = COL_W'(1);
    end else if (32'(cols_raw) > MAX_COLS) begin
      cols_cl = COL_W'(MAX_COLS);
    end else begin
      cols_cl = COL_W'(cols_raw);
    end
    if (k_raw == 5'd0) begin
      k_cl = KD_W'(1);
    end else if (32'(k_raw) > MAX_KERNEL) begin
      k_cl = KD_W'(MAX_KERNEL);
    end else begin
      k_cl = KD_W'(k_raw);
    end
  end

  assign lat_c = PEND_W'(32'((kr_r - 1'b1) >> 1) * 32'(cols_r) + 32'((kc_r - 1'b1) >> 1));

  assign pend_new = (draining_r ? PEND_W'(0) : pend_r) + 1'b1;
  assign emit_pix = (pend_new > lat_c);
  assign in_end   = (icol_r == cols_r - 1'b1) && (irow_r == rows_r - 1'b1);
  assign out_end  = (ocol_r == cols_r - 1'b1) && (orow_r == rows_r - 1'b1);

  // Window start address: output address minus (kr/2)*cols + kc/2, modulo ring
  assign back_c  = (RA_W+1)'(32'(kr_r >> 1) * 32'(cols_r) + 32'(kc_r >> 1));
  assign start_c = ({1'b0, op_r} >= back_c) ? {1'b0, op_r} - back_c
                                            : {1'b0, op_r} + (RA_W+1)'(RING) - back_c;
  assign rsum_c  = {1'b0, ra_r} + (RA_W+1)'(cols_r);
  assign ra_nxt  = (rsum_c >= (RA_W+1)'(RING)) ? RA_W'(rsum_c - (RA_W+1)'(RING))
                                               : RA_W'(rsum_c);
  assign ca_step = (ca_r == RA_W'(RING - 1)) ? '0 : ca_r + 1'b1;

  assign inb = !pr_r[ROW_W+1] && (pr_r[ROW_W:0] < {1'b0, rows_r})
               && !pc_r[COL_W] && (pc_r[COL_W-1:0] < cols_r);
  assign kidx     = KA_W'(32'(ki_r) * MAX_KERNEL + 32'(kj_r));
  assign row_last = (kj_r == kc_r - 1'b1);

  assign div_neg = wsum_r[WS_W-1];
  assign divisor = (wsum_r == '0) ? WS_W'(1) << iecr_pkg::WSUM_ONE
                 : (div_neg ? WS_W'(-wsum_r) : WS_W'(wsum_r));

  assign load = (state_r == S_OUT) && free;
  assign last = out_end;

  assign lane_ctl.wr_en     = acc_pix;
  assign lane_ctl.take      = take_q_r;
  assign lane_ctl.clr       = (state_r == S_SETUP);
  assign lane_ctl.div_start = (state_r == S_DIVST);

  always_ff @(posedge clk) begin
    if (kwr) begin
      kmem[KA_W'(in_ch.coeff_index)] <= in_ch.coeff_value[COEFF_BITS-1:0];
    end
    w_q_r <= kmem[kidx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      rows_r     <= ROW_W'(1);
      cols_r     <= COL_W'(1);
      kr_r       <= KD_W'(1);
      kc_r       <= KD_W'(1);
      irow_r     <= '0;
      icol_r     <= '0;
      orow_r     <= '0;
      ocol_r     <= '0;
      wp_r       <= '0;
      op_r       <= '0;
      pend_r     <= '0;
      draining_r <= 1'b0;
      take_q_r   <= 1'b0;
      ki_r       <= '0;
      kj_r       <= '0;
    end else begin
      take_q_r <= (state_r == S_RUN) && inb;
      if (take_q_r) begin
        wsum_r <= wsum_r + WS_W'(w_q_r);
      end
      case (state_r)
        S_IDLE: begin
          if (acc_in) begin
            case (in_ch.req_type)
              iecr_pkg::REQ_PIXEL: begin
                if (draining_r) begin
                  orow_r <= '0;
                  ocol_r <= '0;
                  op_r   <= '0;
                end
                if (in_end) begin
                  irow_r <= '0;
                  icol_r <= '0;
                  wp_r   <= '0;
                end else begin
                  wp_r <= (wp_r == RA_W'(RING - 1)) ? '0 : wp_r + 1'b1;
                  if (icol_r == cols_r - 1'b1) begin
                    icol_r <= '0;
                    irow_r <= irow_r + 1'b1;
                  end else begin
                    icol_r <= icol_r + 1'b1;
                  end
                end
                pend_r     <= emit_pix ? pend_new - 1'b1 : pend_new;
                draining_r <= in_end && ((emit_pix ? pend_new - 1'b1 : pend_new) != '0);
                if (emit_pix) begin
                  state_r <= S_SETUP;
                end
              end
              iecr_pkg::REQ_FLUSH: begin
                if (draining_r && (pend_r != '0)) begin
                  pend_r     <= pend_r - 1'b1;
                  draining_r <= (pend_r != PEND_W'(1));
                  state_r    <= S_SETUP;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SETUP: begin
          ra_r    <= RA_W'(start_c);
          ca_r    <= RA_W'(start_c);
          pr_r    <= $signed({2'b00, orow_r}) - $signed((ROW_W+2)'(kr_r >> 1));
          pc_r    <= $signed({1'b0, ocol_r}) - $signed((COL_W+1)'(kc_r >> 1));
          pc0_r   <= $signed({1'b0, ocol_r}) - $signed((COL_W+1)'(kc_r >> 1));
          ki_r    <= '0;
          kj_r    <= '0;
          wsum_r  <= '0;
          state_r <= S_RUN;
        end
        S_RUN: begin
          if (row_last) begin
            kj_r <= '0;
            ki_r <= ki_r + 1'b1;
            pr_r <= pr_r + 1'b1;
            pc_r <= pc0_r;
            ra_r <= ra_nxt;
            ca_r <= ra_nxt;
            if (ki_r == kr_r - 1'b1) begin
              state_r <= S_DRAIN1;
            end
          end else begin
            kj_r <= kj_r + 1'b1;
            pc_r <= pc_r + 1'b1;
            ca_r <= ca_step;
          end
        end
        S_DRAIN1: state_r <= S_DRAIN2;
        S_DRAIN2: state_r <= S_DIVST;
        S_DIVST:  state_r <= S_DIV;
        S_DIV: begin
          if (&lane_done) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (free) begin
            if (out_end) begin
              orow_r <= '0;
              ocol_r <= '0;
              op_r   <= '0;
            end else begin
              op_r <= (op_r == RA_W'(RING - 1)) ? '0 : op_r + 1'b1;
              if (ocol_r == cols_r - 1'b1) begin
                ocol_r <= '0;
                orow_r <= orow_r + 1'b1;
              end else begin
                ocol_r <= ocol_r + 1'b1;
              end
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (cfg_we) begin
        case (cfg_idx)
          iecr_pkg::CFG_IMAGE_ROWS:  rows_r <= (cfg_data == '0) ? ROW_W'(1) : cfg_data;
          iecr_pkg::CFG_IMAGE_COLS:  cols_r <= cols_cl;
          iecr_pkg::CFG_KERNEL_ROWS: kr_r   <= k_cl;
          iecr_pkg::CFG_KERNEL_COLS: kc_r   <= k_cl;
          default: begin
          end
        endcase
        irow_r     <= '0;
        icol_r     <= '0;
        orow_r     <= '0;
        ocol_r     <= '0;
        wp_r       <= '0;
        op_r       <= '0;
        pend_r     <= '0;
        draining_r <= 1'b0;
      end
    end
  end

  for (genvar g = 0; g < NCH; g++) begin : g_lane
    iecr_lane #(
      .DEPTH      (RING),
      .COEFF_BITS (COEFF_BITS),
      .ACC_W      (ACC_W),
      .WS_W       (WS_W)
    ) u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (lane_ctl),
      .wr_addr (wp_r),
      .wr_data (px[g]),
      .rd_addr (ca_r),
      .wgt     (w_q_r),
      .divisor (divisor),
      .div_neg (div_neg),
      .q_mag   (q_mag[g]),
      .q_neg   (q_neg[g]),
      .done    (lane_done[g])
    );
  end

  iecr_merge #(
    .ACC_W (ACC_W)
  ) u_merge (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (load),
    .q_mag  (q_mag),
    .q_neg  (q_neg),
    .last   (last),
    .free   (free),
    .out_ch (out_ch)
  );

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n) pend_r <= lat_c)
    else $error("pending count above latency");
  a_drain_pend: assert property (@(posedge clk) disable iff (!rst_n)
    draining_r |-> (pend_r != '0))
    else $error("draining with nothing pending");
  a_win_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> ((ki_r < kr_r) && (kj_r < kc_r)))
    else $error("window index out of kernel");
  a_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> ((lane_done == '0) || (lane_done == '1)))
    else $error("lane dividers out of step");

endmodule
